// File: rtl/hpst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpst_pkg: shared types and codes of the host power state tracker
// Holds the power state, context, event and transition codes, register
// indexes and reset values, and the structs passed between the modules.
// ----------------------------------------------------------------------------
package hpst_pkg;

    localparam int TimeWidth  = 32;
    localparam int CountWidth = 32;

    // power states
    localparam logic [1:0] ST_OFF  = 2'd0;
    localparam logic [1:0] ST_BOOT = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_SHUT = 2'd3;

    // context codes
    localparam logic [2:0] CX_NONE     = 3'd0;
    localparam logic [2:0] CX_BOOTING  = 3'd1;
    localparam logic [2:0] CX_BOOTDONE = 3'd2;
    localparam logic [2:0] CX_SHUT     = 3'd3;
    localparam logic [2:0] CX_OFF      = 3'd4;
    localparam logic [2:0] CX_RUN      = 3'd5;
    localparam logic [2:0] CX_WAIT     = 3'd6;

    // event kinds
    localparam logic [1:0] OP_STATS = 2'd0;
    localparam logic [1:0] OP_LOG   = 2'd1;
    localparam logic [1:0] OP_TRANS = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // transition codes
    localparam logic [2:0] TR_BOOT_START = 3'd1;
    localparam logic [2:0] TR_BOOT_DONE  = 3'd2;
    localparam logic [2:0] TR_SHUTDOWN   = 3'd3;
    localparam logic [2:0] TR_POWEROFF   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_STATS_STALE   = 2'd0;
    localparam logic [1:0] REG_LOG_WINDOW    = 2'd1;
    localparam logic [1:0] REG_SHUTDOWN_QUIET = 2'd2;

    localparam logic [TimeWidth-1:0] STATS_STALE_RESET    = 32'd5000;
    localparam logic [TimeWidth-1:0] LOG_WINDOW_RESET     = 32'd5000;
    localparam logic [TimeWidth-1:0] SHUTDOWN_QUIET_RESET = 32'd10000;

    typedef struct packed {
        logic [TimeWidth-1:0] stats_stale;
        logic [TimeWidth-1:0] log_window;
        logic [TimeWidth-1:0] shutdown_quiet;
    } hpst_cfg_t;

    typedef struct packed {
        logic [1:0]            power_state;
        logic [TimeWidth-1:0]  stats_time;
        logic [TimeWidth-1:0]  log_time;
        logic [TimeWidth-1:0]  boot_start_time;
        logic [TimeWidth-1:0]  boot_done_time;
        logic [TimeWidth-1:0]  shutdown_time;
        logic [TimeWidth-1:0]  poweroff_time;
        logic                  boot_done_flag;
        logic [CountWidth-1:0] reject_count;
    } hpst_state_t;

    typedef struct packed {
        logic       state_changed;
        logic [2:0] context_code;
        logic       rejected;
    } hpst_result_t;

endpackage

// File: rtl/hpst_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpst_eval: single-event evaluation logic
// Applies one event to the tracker state: records evidence, re-evaluates the
// power state from recent evidence and produces the next state and result.
// ----------------------------------------------------------------------------
module hpst_eval (
    input  hpst_pkg::hpst_cfg_t              cfg,
    input  hpst_pkg::hpst_state_t            cur,
    input  logic [1:0]                       op,
    input  logic [hpst_pkg::TimeWidth-1:0]   time_ms,
    input  logic [2:0]                       transition_code,
    output hpst_pkg::hpst_state_t            nxt,
    output hpst_pkg::hpst_result_t           res
);

    hpst_pkg::hpst_state_t            ev;
    logic                             code_ok;
    logic [hpst_pkg::TimeWidth-1:0]   stats_age;
    logic [hpst_pkg::TimeWidth-1:0]   log_age;
    logic [hpst_pkg::TimeWidth-1:0]   latest;
    logic [hpst_pkg::TimeWidth-1:0]   latest_age;
    logic                             stats_recent;
    logic                             log_recent;
    logic                             shut_active;
    logic                             shut_quiet;
    logic [2:0]                       boot_ctx;
    logic [1:0]                       eval_state;
    logic [2:0]                       eval_ctx;

    assign code_ok = transition_code inside {[hpst_pkg::TR_BOOT_START:hpst_pkg::TR_POWEROFF]};

    // record the evidence carried by this event
    always_comb begin
        ev = cur;
        case (op)
            hpst_pkg::OP_STATS: begin
                ev.stats_time = time_ms;
            end
            hpst_pkg::OP_LOG: begin
                ev.log_time = time_ms;
            end
            hpst_pkg::OP_TRANS: begin
                if (code_ok) begin
                    ev.log_time = time_ms;
                    case (transition_code)
                        hpst_pkg::TR_BOOT_START: begin
                            ev.boot_start_time = time_ms;
                            ev.boot_done_flag  = 1'b0;
                        end
                        hpst_pkg::TR_BOOT_DONE: begin
                            ev.boot_done_time = time_ms;
                            ev.boot_done_flag = 1'b1;
                        end
                        hpst_pkg::TR_SHUTDOWN: begin
                            ev.shutdown_time  = time_ms;
                            ev.boot_done_flag = 1'b0;
                        end
                        default: begin
                            ev.poweroff_time  = time_ms;
                            ev.boot_done_flag = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    assign stats_age  = time_ms - ev.stats_time;
    assign log_age    = time_ms - ev.log_time;
    assign latest     = (ev.shutdown_time > ev.poweroff_time) ? ev.shutdown_time
                                                               : ev.poweroff_time;
    assign latest_age = time_ms - latest;

    assign stats_recent = (ev.stats_time != '0) && (stats_age < cfg.stats_stale);
    assign log_recent   = (ev.log_time != '0) && (log_age < cfg.log_window);
    assign shut_active  = (latest != '0) && (latest_age < cfg.log_window) &&
                          (latest >= ev.boot_start_time);
    assign shut_quiet   = (latest != '0) && (latest_age < cfg.shutdown_quiet);
    assign boot_ctx     = ((ev.boot_done_time != '0) &&
                           (ev.boot_done_time >= ev.boot_start_time))
                          ? hpst_pkg::CX_BOOTDONE : hpst_pkg::CX_BOOTING;

    // pick the next power state from the evidence
    always_comb begin
        eval_state = hpst_pkg::ST_OFF;
        eval_ctx   = hpst_pkg::CX_OFF;
        case (cur.power_state)
            hpst_pkg::ST_SHUT: begin
                if (stats_recent && (ev.stats_time > latest)) begin
                    eval_state = hpst_pkg::ST_RUN;
                    eval_ctx   = hpst_pkg::CX_RUN;
                end else if (log_recent || shut_quiet) begin
                    eval_state = hpst_pkg::ST_SHUT;
                    eval_ctx   = hpst_pkg::CX_SHUT;
                end
            end
            hpst_pkg::ST_RUN: begin
                if (shut_active) begin
                    eval_state = hpst_pkg::ST_SHUT;
                    eval_ctx   = hpst_pkg::CX_SHUT;
                end else if (stats_recent || log_recent) begin
                    eval_state = hpst_pkg::ST_RUN;
                    eval_ctx   = hpst_pkg::CX_RUN;
                end
            end
            hpst_pkg::ST_BOOT: begin
                if (stats_recent) begin
                    eval_state = hpst_pkg::ST_RUN;
                    eval_ctx   = hpst_pkg::CX_RUN;
                end else begin
                    eval_state = hpst_pkg::ST_BOOT;
                    eval_ctx   = boot_ctx;
                end
            end
            default: begin
                if (stats_recent) begin
                    eval_state = hpst_pkg::ST_RUN;
                    eval_ctx   = hpst_pkg::CX_RUN;
                end else if (log_recent && !shut_active) begin
                    eval_state = hpst_pkg::ST_BOOT;
                    eval_ctx   = boot_ctx;
                end
            end
        endcase
    end

    // apply state entry side effects and the per-event follow-ups
    always_comb begin
        nxt = ev;
        res.state_changed = 1'b0;
        res.context_code  = hpst_pkg::CX_NONE;
        res.rejected      = 1'b0;
        if ((op == hpst_pkg::OP_TRANS) && !code_ok) begin
            nxt = cur;
            nxt.reject_count = cur.reject_count + {{(hpst_pkg::CountWidth-1){1'b0}}, 1'b1};
            res.rejected     = 1'b1;
        end else begin
            res.context_code = eval_ctx;
            nxt.power_state  = eval_state;
            if (eval_state != cur.power_state) begin
                res.state_changed = 1'b1;
                if (eval_state != hpst_pkg::ST_RUN) begin
                    nxt.stats_time = '0;
                end
                if ((eval_state == hpst_pkg::ST_OFF) || (eval_state == hpst_pkg::ST_SHUT)) begin
                    nxt.boot_done_flag = 1'b0;
                end
                if (eval_state == hpst_pkg::ST_OFF) begin
                    nxt.log_time        = '0;
                    nxt.boot_start_time = '0;
                    nxt.boot_done_time  = '0;
                    nxt.shutdown_time   = '0;
                    nxt.poweroff_time   = '0;
                end
            end
            if ((op == hpst_pkg::OP_STATS) && (eval_state == hpst_pkg::ST_RUN)) begin
                nxt.boot_done_flag = 1'b0;
            end
            // expire stale stats on a tick while running
            if ((op == hpst_pkg::OP_TICK) && (eval_state == hpst_pkg::ST_RUN) &&
                (ev.stats_time != '0) && (stats_age >= cfg.stats_stale)) begin
                nxt.stats_time   = '0;
                res.context_code = hpst_pkg::CX_WAIT;
            end
        end
    end

endmodule

// File: rtl/host_power_state_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// host_power_state_tracker_unit: host power state inference from events
// Infers off / booting / running / shutting down from timestamped evidence.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one event per transaction; s_tuser carries the event
//   kind, s_tdata the timestamp and transition code. Result stream m_*: one
//   result per event, in order. Configuration channel cfg_*: write the three
//   window registers by index; writes are always taken (cfg_ready is high)
//   and are meant to happen only while no event is in flight.
//   An accepted event is held in the input register, evaluated out of it and
//   its result is registered in the result register that drives m_*.
//   Throughput: one event per cycle while the result register is free or
//   m_tready is high; the state update of one event is combinational
//   subtract/compare logic feeding the state registers.
//   Stall: while m_tready is low the result holds; one more event waits in
//   the input register, after which s_tready drops until the result moves.
//   Reset (aresetn low, synchronous): state off, all timestamps and the
//   reject count cleared, windows back to 5000 / 5000 / 10000 ms.
// ----------------------------------------------------------------------------
module host_power_state_tracker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] time_ms, [34:32] transition_code
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [1:0] power_state, [2] state_changed,
                                   // [5:3] context_code, [6] boot_pending,
                                   // [7] transition_rejected, [39:8] rejected_total
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    hpst_pkg::hpst_cfg_t              cfg_reg;
    hpst_pkg::hpst_state_t            state_reg;
    hpst_pkg::hpst_state_t            state_next;
    hpst_pkg::hpst_result_t           res;
    logic                             in_valid_reg;
    logic [1:0]                       in_op_reg;
    logic [hpst_pkg::TimeWidth-1:0]   in_time_reg;
    logic [2:0]                       in_code_reg;
    logic                             out_valid_reg;
    logic [39:0]                      out_data_reg;
    logic                             s_accept;
    logic                             advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    hpst_eval u_eval (
        .cfg             (cfg_reg),
        .cur             (state_reg),
        .op              (in_op_reg),
        .time_ms         (in_time_reg),
        .transition_code (in_code_reg),
        .nxt             (state_next),
        .res             (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stats_stale    <= hpst_pkg::STATS_STALE_RESET;
            cfg_reg.log_window     <= hpst_pkg::LOG_WINDOW_RESET;
            cfg_reg.shutdown_quiet <= hpst_pkg::SHUTDOWN_QUIET_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                hpst_pkg::REG_STATS_STALE:    cfg_reg.stats_stale    <= cfg_data;
                hpst_pkg::REG_LOG_WINDOW:     cfg_reg.log_window     <= cfg_data;
                hpst_pkg::REG_SHUTDOWN_QUIET: cfg_reg.shutdown_quiet <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg   <= s_tuser;
            in_time_reg <= s_tdata[31:0];
            in_code_reg <= s_tdata[34:32];
        end
    end

    // tracker state advances once per evaluated event
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {state_next.reject_count, res.rejected,
                             state_next.boot_done_flag, res.context_code,
                             res.state_changed, state_next.power_state};
        end
    end

    // the reject count moves only on a rejected transition
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !res.rejected) |=> $stable(state_reg.reject_count))
        else $error("reject count changed without a rejected transition");

    // entering off leaves no evidence behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.state_changed && (state_next.power_state == hpst_pkg::ST_OFF))
        |=> ((state_reg.log_time == '0) && (state_reg.stats_time == '0) &&
             (state_reg.shutdown_time == '0) && (state_reg.poweroff_time == '0) &&
             (state_reg.boot_start_time == '0) && (state_reg.boot_done_time == '0)))
        else $error("timestamps not cleared on entering off");

    // a rejected transition never changes the power state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.rejected) |=> $stable(state_reg.power_state))
        else $error("rejected transition changed the power state");

endmodule

// File: tb/host_power_state_tracker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// host_power_state_tracker_unit_tb: self-checking bench for the power tracker
// Drives timestamped events through the input stream and keeps its own copy
// of the tracker state to predict every result. Runs a directed sweep of the
// corner cases, then random boot/run/shutdown lifecycles mixed with noise
// under several window settings, with random idling on both streams and one
// long result-side stall.
// ----------------------------------------------------------------------------
module host_power_state_tracker_unit_tb;

    localparam int          LIMIT_CYCLES = 100000;
    localparam int          STALL_LEN    = 200;
    localparam int          SETTLE_CYCLES = 4;
    localparam logic [2:0]  TR_NONE       = 3'd0;
    localparam logic [2:0]  TR_RSVD_FIRST = 3'd5;
    localparam logic [2:0]  TR_RSVD_LAST  = 3'd7;
    localparam logic [31:0] WINDOW_MIN    = 32'd1;
    localparam logic [31:0] WINDOW_MAX    = 32'hFFFF_FFFF;
    localparam int          LP_BOOT = 0;
    localparam int          LP_RUN  = 1;
    localparam int          LP_SHUT = 2;

    typedef struct {
        logic [1:0]  power_state;
        logic        state_changed;
        logic [2:0]  ctx_code;
        logic        boot_pending;
        logic        rejected;
        logic [31:0] rejected_total;
    } report_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // tracker copy
    logic [1:0]  cur_state;
    logic [31:0] t_stats, t_log, t_boot_start, t_boot_done, t_shut, t_poff;
    logic        done_flag;
    logic [31:0] rej_cnt;
    logic [31:0] win_stats, win_log, win_quiet;

    report_t     pending_reports[$];
    int unsigned cycle_count = 0;
    int          fail_count  = 0;
    bit          idle_on     = 1'b1;
    int          stall_seq   = 0;
    int          stall_seen  = 0;
    int          hold_left   = 0;
    logic [31:0] now_ms      = '0;
    int          life_phase  = LP_BOOT;

    host_power_state_tracker_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL host_power_state_tracker_unit");
            $finish;
        end
    end

    // ---------------- prediction ----------------

    function automatic bit recent(logic [31:0] stamp, logic [31:0] now, logic [31:0] window);
        logic [31:0] age;
        age = now - stamp;
        return (stamp != 32'd0) && (age < window);
    endfunction

    function automatic void enter_state(logic [1:0] nxt);
        cur_state = nxt;
        if (nxt != hpst_pkg::ST_RUN)
            t_stats = '0;
        if (nxt == hpst_pkg::ST_OFF || nxt == hpst_pkg::ST_SHUT)
            done_flag = 1'b0;
        if (nxt == hpst_pkg::ST_OFF) begin
            t_log        = '0;
            t_boot_start = '0;
            t_boot_done  = '0;
            t_shut       = '0;
            t_poff       = '0;
        end
    endfunction

    // Re-derive the power state from the stored evidence; return the context.
    function automatic logic [2:0] infer_state(logic [31:0] now);
        bit          fresh_stats, fresh_log, shut_active, shut_quiet;
        logic [31:0] latest;
        logic [1:0]  nxt;
        logic [2:0]  ctx, boot_ctx;
        fresh_stats = recent(t_stats, now, win_stats);
        fresh_log   = recent(t_log, now, win_log);
        latest      = (t_shut > t_poff) ? t_shut : t_poff;
        shut_active = recent(latest, now, win_log) && (latest >= t_boot_start);
        shut_quiet  = recent(latest, now, win_quiet);
        boot_ctx    = (t_boot_done != 0 && t_boot_done >= t_boot_start)
                      ? hpst_pkg::CX_BOOTDONE : hpst_pkg::CX_BOOTING;
        case (cur_state)
            hpst_pkg::ST_SHUT: begin
                if (fresh_stats && t_stats > latest) begin
                    nxt = hpst_pkg::ST_RUN;  ctx = hpst_pkg::CX_RUN;
                end else if (fresh_log || shut_quiet) begin
                    nxt = hpst_pkg::ST_SHUT; ctx = hpst_pkg::CX_SHUT;
                end else begin
                    nxt = hpst_pkg::ST_OFF;  ctx = hpst_pkg::CX_OFF;
                end
            end
            hpst_pkg::ST_RUN: begin
                if (shut_active) begin
                    nxt = hpst_pkg::ST_SHUT; ctx = hpst_pkg::CX_SHUT;
                end else if (fresh_stats || fresh_log) begin
                    nxt = hpst_pkg::ST_RUN;  ctx = hpst_pkg::CX_RUN;
                end else begin
                    nxt = hpst_pkg::ST_OFF;  ctx = hpst_pkg::CX_OFF;
                end
            end
            hpst_pkg::ST_BOOT: begin
                if (fresh_stats) begin
                    nxt = hpst_pkg::ST_RUN;  ctx = hpst_pkg::CX_RUN;
                end else begin
                    nxt = hpst_pkg::ST_BOOT; ctx = boot_ctx;
                end
            end
            default: begin
                if (fresh_stats) begin
                    nxt = hpst_pkg::ST_RUN;  ctx = hpst_pkg::CX_RUN;
                end else if (fresh_log && !shut_active) begin
                    nxt = hpst_pkg::ST_BOOT; ctx = boot_ctx;
                end else begin
                    nxt = hpst_pkg::ST_OFF;  ctx = hpst_pkg::CX_OFF;
                end
            end
        endcase
        if (nxt != cur_state)
            enter_state(nxt);
        return ctx;
    endfunction

    function automatic report_t track_event(logic [1:0] op, logic [31:0] t, logic [2:0] code);
        report_t     r;
        logic [1:0]  prior;
        logic [31:0] stats_age;
        prior      = cur_state;
        r.ctx_code = hpst_pkg::CX_NONE;
        r.rejected = 1'b0;
        case (op)
            hpst_pkg::OP_STATS: begin
                t_stats    = t;
                r.ctx_code = infer_state(t);
                if (cur_state == hpst_pkg::ST_RUN)
                    done_flag = 1'b0;
            end
            hpst_pkg::OP_LOG: begin
                t_log      = t;
                r.ctx_code = infer_state(t);
            end
            hpst_pkg::OP_TRANS: begin
                if (code < hpst_pkg::TR_BOOT_START || code > hpst_pkg::TR_POWEROFF) begin
                    rej_cnt    = rej_cnt + 32'd1;
                    r.rejected = 1'b1;
                end else begin
                    t_log = t;
                    case (code)
                        hpst_pkg::TR_BOOT_START: begin t_boot_start = t; done_flag = 1'b0; end
                        hpst_pkg::TR_BOOT_DONE:  begin t_boot_done  = t; done_flag = 1'b1; end
                        hpst_pkg::TR_SHUTDOWN:   begin t_shut       = t; done_flag = 1'b0; end
                        default:                 begin t_poff       = t; done_flag = 1'b0; end
                    endcase
                    r.ctx_code = infer_state(t);
                end
            end
            default: begin
                r.ctx_code = infer_state(t);
                stats_age  = t - t_stats;
                // expire stale stats while running
                if (cur_state == hpst_pkg::ST_RUN && t_stats != 0 && stats_age >= win_stats) begin
                    t_stats    = '0;
                    r.ctx_code = hpst_pkg::CX_WAIT;
                end
            end
        endcase
        r.power_state    = cur_state;
        r.state_changed  = (cur_state != prior);
        r.boot_pending   = done_flag;
        r.rejected_total = rej_cnt;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            pending_reports.push_back(track_event(s_tuser, s_tdata[31:0], s_tdata[34:32]));
    end

    // ---------------- checking ----------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        report_t r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $error("result with no event outstanding: m_tdata %0h", m_tdata);
                fail_count++;
            end else begin
                r = pending_reports.pop_front();
                check_field("power_state", 32'(r.power_state), 32'(m_tdata[1:0]));
                check_field("state_changed", 32'(r.state_changed), 32'(m_tdata[2]));
                check_field("context_code", 32'(r.ctx_code), 32'(m_tdata[5:3]));
                check_field("boot_pending", 32'(r.boot_pending), 32'(m_tdata[6]));
                check_field("transition_rejected", 32'(r.rejected), 32'(m_tdata[7]));
                check_field("rejected_total", r.rejected_total, m_tdata[39:8]);
            end
        end
    end

    // Result-side ready: random idling, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (stall_seen != stall_seq) begin
            stall_seen = stall_seq;
            hold_left  = STALL_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (idle_on) begin
            m_tready <= ($urandom_range(99) >= 14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_event(input logic [1:0] op, input logic [31:0] t,
                              input logic [2:0] code);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, code, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (idle_on) begin
            while ($urandom_range(99) < 14) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
    endtask

    // Drop valid and wait for every outstanding result, then the pipeline.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            hpst_pkg::REG_STATS_STALE: win_stats = value;
            hpst_pkg::REG_LOG_WINDOW:  win_log   = value;
            default:                   win_quiet = value;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_windows(input logic [31:0] stale, input logic [31:0] logw,
                               input logic [31:0] quiet);
        settle();
        write_reg(hpst_pkg::REG_STATS_STALE, stale);
        write_reg(hpst_pkg::REG_LOG_WINDOW, logw);
        write_reg(hpst_pkg::REG_SHUTDOWN_QUIET, quiet);
    endtask

    // Mostly well-formed boot / run / shutdown lifecycles, some pure noise.
    task automatic rand_events(input int count);
        int          k, roll;
        logic [1:0]  op;
        logic [2:0]  code;
        logic [31:0] stamp;
        for (k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll >= 75 && roll < 95)
                now_ms += $urandom_range(2500, 12000);
            else if (roll >= 95)
                now_ms += $urandom;
            else if (roll >= 20)
                now_ms += $urandom_range(1, 2500);
            op    = hpst_pkg::OP_TICK;
            code  = 3'($urandom_range(7));
            stamp = now_ms;
            roll  = $urandom_range(99);
            if ($urandom_range(99) < 12) begin
                op = 2'($urandom_range(3));
                if ($urandom_range(1))
                    stamp = $urandom;
            end else begin
                case (life_phase)
                    LP_BOOT: begin
                        if (roll < 40) begin
                            op = hpst_pkg::OP_LOG;
                        end else if (roll < 60) begin
                            op = hpst_pkg::OP_TRANS; code = hpst_pkg::TR_BOOT_START;
                        end else if (roll < 80) begin
                            op = hpst_pkg::OP_TRANS; code = hpst_pkg::TR_BOOT_DONE;
                            life_phase = LP_RUN;
                        end
                    end
                    LP_RUN: begin
                        if (roll < 45) begin
                            op = hpst_pkg::OP_STATS;
                        end else if (roll < 65) begin
                            op = hpst_pkg::OP_TICK;
                        end else if (roll < 80) begin
                            op = hpst_pkg::OP_LOG;
                        end else if (roll < 88) begin
                            op = hpst_pkg::OP_TRANS; code = hpst_pkg::TR_BOOT_DONE;
                        end else begin
                            op = hpst_pkg::OP_TRANS;
                            code = $urandom_range(1) ? hpst_pkg::TR_SHUTDOWN
                                                     : hpst_pkg::TR_POWEROFF;
                            life_phase = LP_SHUT;
                        end
                    end
                    default: begin
                        if (roll < 35) begin
                            op = hpst_pkg::OP_LOG;
                        end else if (roll < 60) begin
                            op = hpst_pkg::OP_TICK;
                        end else if (roll < 75) begin
                            op = hpst_pkg::OP_TRANS;
                            code = $urandom_range(1) ? hpst_pkg::TR_SHUTDOWN
                                                     : hpst_pkg::TR_POWEROFF;
                        end else if (roll < 85) begin
                            op = hpst_pkg::OP_STATS;
                        end else begin
                            // long quiet gap, host should fall to off
                            now_ms += $urandom_range(15000, 40000);
                            stamp = now_ms;
                            life_phase = LP_BOOT;
                        end
                    end
                endcase
            end
            send_event(op, stamp, code);
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_directed();
        int c;
        send_event(hpst_pkg::OP_TICK, 32'd100, TR_NONE);
        send_event(hpst_pkg::OP_TRANS, 32'd200, TR_NONE);
        for (c = int'(TR_RSVD_FIRST); c <= int'(TR_RSVD_LAST); c++)
            send_event(hpst_pkg::OP_TRANS, 32'd300, c[2:0]);
        send_event(hpst_pkg::OP_LOG, 32'd1000, TR_NONE);
        send_event(hpst_pkg::OP_TRANS, 32'd1200, hpst_pkg::TR_BOOT_START);
        send_event(hpst_pkg::OP_TRANS, 32'd1500, hpst_pkg::TR_BOOT_DONE);
        send_event(hpst_pkg::OP_STATS, 32'd2000, TR_NONE);
        send_event(hpst_pkg::OP_TICK, 32'd3000, TR_NONE);
        send_event(hpst_pkg::OP_LOG, 32'd6000, TR_NONE);
        // stats stale, log still fresh: expiry on the tick
        send_event(hpst_pkg::OP_TICK, 32'd7500, TR_NONE);
        send_event(hpst_pkg::OP_TRANS, 32'd8000, hpst_pkg::TR_SHUTDOWN);
        send_event(hpst_pkg::OP_LOG, 32'd9000, TR_NONE);
        send_event(hpst_pkg::OP_TICK, 32'd20000, TR_NONE);
        send_event(hpst_pkg::OP_STATS, 32'd0, TR_NONE);
        // evidence across the 32-bit wrap
        send_event(hpst_pkg::OP_LOG, 32'hFFFF_FF00, TR_NONE);
        send_event(hpst_pkg::OP_STATS, 32'h0000_0100, TR_NONE);
        send_event(hpst_pkg::OP_TRANS, 32'h0000_0300, hpst_pkg::TR_POWEROFF);
        send_event(hpst_pkg::OP_STATS, 32'h0000_0400, TR_NONE);
        send_event(hpst_pkg::OP_TICK, 32'hFFFF_FFFF, TR_NONE);
        send_event(hpst_pkg::OP_STATS, 32'hFFFF_FFFF, TR_RSVD_LAST);
        send_event(hpst_pkg::OP_TRANS, 32'hFFFF_FFFF, TR_RSVD_LAST);
    endtask

    task automatic test_lifecycle();
        settle();
        now_ms = 32'hFFFF_F000;
        rand_events(120);
    endtask

    task automatic test_steady_flow();
        settle();
        idle_on = 1'b0;
        rand_events(70);
        settle();
        idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        settle();
        stall_seq++;
        rand_events(40);
    endtask

    task automatic test_window_min();
        set_windows(WINDOW_MIN, WINDOW_MIN, WINDOW_MIN);
        now_ms = $urandom;
        rand_events(55);
    endtask

    task automatic test_window_max();
        set_windows(WINDOW_MAX, WINDOW_MAX, WINDOW_MAX);
        now_ms = $urandom;
        rand_events(55);
    endtask

    task automatic test_window_mixed();
        set_windows($urandom_range(1, 20000), $urandom_range(1, 20000),
                    $urandom_range(1, 30000));
        rand_events(60);
    endtask

    initial begin
        cur_state    = hpst_pkg::ST_OFF;
        t_stats      = '0;
        t_log        = '0;
        t_boot_start = '0;
        t_boot_done  = '0;
        t_shut       = '0;
        t_poff       = '0;
        done_flag    = 1'b0;
        rej_cnt      = '0;
        win_stats    = hpst_pkg::STATS_STALE_RESET;
        win_log      = hpst_pkg::LOG_WINDOW_RESET;
        win_quiet    = hpst_pkg::SHUTDOWN_QUIET_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_lifecycle();
        test_steady_flow();
        test_output_stall();
        test_window_min();
        test_window_max();
        test_window_mixed();
        settle();
        if (fail_count == 0)
            $display("PASS host_power_state_tracker_unit");
        else
            $display("FAIL host_power_state_tracker_unit");
        $finish;
    end

endmodule

// File: host_power_state_tracker_unit.f
rtl/hpst_pkg.sv
rtl/hpst_eval.sv
rtl/host_power_state_tracker_unit.sv
tb/host_power_state_tracker_unit_tb.sv
